// ===== hdl/ose_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ose_pkg: shared definitions of the ordered set engine
// Command and status codes, cell operation codes and the control struct that
// the top level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package ose_pkg;

    typedef logic [3:0] t_cmd;
    typedef logic [1:0] t_status;
    typedef logic [2:0] t_wr_op;
    typedef logic [2:0] t_sel_op;

    localparam t_cmd CMD_INSERT      = 4'd0;
    localparam t_cmd CMD_REMOVE      = 4'd1;
    localparam t_cmd CMD_EXISTS      = 4'd2;
    localparam t_cmd CMD_MIN         = 4'd3;
    localparam t_cmd CMD_MAX         = 4'd4;
    localparam t_cmd CMD_EXTRACT_MIN = 4'd5;
    localparam t_cmd CMD_EXTRACT_MAX = 4'd6;
    localparam t_cmd CMD_PRED        = 4'd7;
    localparam t_cmd CMD_PRED_REMOVE = 4'd8;
    localparam t_cmd CMD_SUCC        = 4'd9;
    localparam t_cmd CMD_SUCC_REMOVE = 4'd10;
    localparam t_cmd CMD_CLEAR       = 4'd11;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_EMPTY     = 2'd1;
    localparam t_status ST_NOT_FOUND = 2'd2;
    localparam t_status ST_FULL      = 2'd3;

    // What a cell loads into its key register in the apply cycle.
    localparam t_wr_op WR_HOLD    = 3'd0;  // keep own key
    localparam t_wr_op WR_INSERT  = 3'd1;  // open a gap at the first key >= k
    localparam t_wr_op WR_RM_LT   = 3'd2;  // close up from the first key >= k
    localparam t_wr_op WR_RM_LE   = 3'd3;  // close up from the first key > k
    localparam t_wr_op WR_RM_PRED = 3'd4;  // close up from the last key < k
    localparam t_wr_op WR_RM_ALL  = 3'd5;  // close up from the bottom

    // Which cell drives its key onto the result bus.
    localparam t_sel_op SEL_NONE = 3'd0;
    localparam t_sel_op SEL_MIN  = 3'd1;
    localparam t_sel_op SEL_MAX  = 3'd2;
    localparam t_sel_op SEL_PRED = 3'd3;
    localparam t_sel_op SEL_SUCC = 3'd4;

    typedef struct packed {
        logic    search;  // compare own key with the broadcast key
        t_wr_op  wr_op;
        t_sel_op sel_op;
    } t_cell_ctl;

endpackage

// ===== hdl/ose_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ose_cell: one slot of the sorted key chain
// Holds one key, compares it with the broadcast key and shifts keys to or
// from its neighbours when an entry is opened or closed up.
// ----------------------------------------------------------------------------
module ose_cell #(
    parameter int KEY_WIDTH = 32,
    parameter int CNT_W     = 7,
    parameter int IDX       = 0
) (
    input  logic                 i_clk,
    input  ose_pkg::t_cell_ctl   i_ctl,
    input  logic [KEY_WIDTH-1:0] i_key,
    input  logic [CNT_W-1:0]     i_count,
    input  logic [KEY_WIDTH-1:0] i_prv_key,
    input  logic                 i_prv_lt,
    input  logic                 i_prv_le,
    input  logic [KEY_WIDTH-1:0] i_nxt_key,
    input  logic                 i_nxt_lt,
    input  logic                 i_nxt_occ,
    output logic [KEY_WIDTH-1:0] o_key,
    output logic                 o_lt,
    output logic                 o_le,
    output logic                 o_occ,
    output logic [KEY_WIDTH-1:0] o_pick
);
    import ose_pkg::*;

    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic                 r_lt, r_le;
    logic                 w_occ, w_sel;

    assign w_occ = CNT_W'(IDX) < i_count;

    always_comb begin
        n_key = r_key;
        unique case (i_ctl.wr_op)
            WR_HOLD:    n_key = r_key;
            WR_INSERT: begin
                if (!r_lt) begin
                    n_key = i_prv_lt ? i_key : i_prv_key;
                end
            end
            WR_RM_LT:   if (!r_lt) n_key = i_nxt_key;
            WR_RM_LE:   if (!r_le) n_key = i_nxt_key;
            WR_RM_PRED: if (!i_nxt_lt) n_key = i_nxt_key;
            WR_RM_ALL:  n_key = i_nxt_key;
            default:    n_key = r_key;
        endcase
    end

    always_comb begin
        unique case (i_ctl.sel_op)
            SEL_NONE: w_sel = 1'b0;
            SEL_MIN:  w_sel = (IDX == 0);
            SEL_MAX:  w_sel = w_occ && !i_nxt_occ;
            SEL_PRED: w_sel = r_lt && !i_nxt_lt;
            SEL_SUCC: w_sel = w_occ && !r_le && i_prv_le;
            default:  w_sel = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (i_ctl.search) begin
            r_lt <= w_occ && (r_key < i_key);
            r_le <= w_occ && (r_key <= i_key);
        end
    end

    assign o_key  = r_key;
    assign o_lt   = r_lt;
    assign o_le   = r_le;
    assign o_occ  = w_occ;
    assign o_pick = w_sel ? r_key : '0;

endmodule

// ===== hdl/ordered_set_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_set_engine: sorted set of distinct keys in a chain of cells
// Keeps up to CAPACITY distinct unsigned keys in ascending order and serves
// insert, remove, exists, min, max, extract, predecessor, successor and clear.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Word
//  request   in         i_in_valid / o_in_stall   i_command, i_key
//  result    out        o_out_valid / i_out_stall o_status, o_value, o_hit,
//                                                 o_count
//
// Each request word is handled as follows: at the accept edge every cell compares
// its key with the request key and stores a less-than and a less-or-equal
// flag; in the following apply cycle the result is decoded from those flags
// and every cell loads a key from itself or a neighbour in one step.
// No new request is taken during an apply cycle, since the apply cycle of
// the chain keeps the next compare out.
// Reset (synchronous, active low) empties the set by zeroing the key count;
// the key registers themselves are not cleared and need no sweep.
// A stalled result holds in the output register and holds off new requests.
//
// Cell i is occupied when i is below the key count. Keys are sorted, so the
// less-than flags form a run of ones from cell 0 up to the insertion point,
// and the less-or-equal flags a run up to the successor position. Each cell
// finds its own role (insertion point, predecessor, successor, maximum)
// from its flags and those of its neighbours.
// ----------------------------------------------------------------------------
module ordered_set_engine #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  ose_pkg::t_cmd                    i_command,
    input  logic [31:0]                      i_key,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output ose_pkg::t_status                 o_status,
    output logic [31:0]                      o_value,
    output logic                             o_hit,
    output logic [$clog2(CAPACITY+1)-1:0]    o_count
);
    import ose_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Chain wiring.
    logic [KEY_WIDTH-1:0] w_key  [CAPACITY];
    logic [KEY_WIDTH-1:0] w_pick [CAPACITY];
    logic [CAPACITY-1:0]  w_lt, w_le, w_occ;

    // Control and data registers.
    logic                 r_busy;
    t_cmd                 r_cmd;
    logic [KEY_WIDTH-1:0] r_key;
    logic [CNT_W-1:0]     r_count, n_count;

    logic                 r_out_valid;
    t_status              r_status, n_status;
    logic [31:0]          r_value;
    logic                 r_hit, n_hit;

    logic                 w_accept;
    logic [63:0]          w_key64;
    logic [KEY_WIDTH-1:0] w_key_in, w_cell_key, w_pick_or;
    logic [63:0]          w_pick64;
    t_cell_ctl            w_ctl;
    logic                 w_empty, w_full, w_found, w_pred_ok, w_succ_ok;

    assign o_in_stall = r_busy || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;

    // The key is taken modulo 2^KEY_WIDTH.
    assign w_key64    = 64'(i_key);
    assign w_key_in   = w_key64[KEY_WIDTH-1:0];
    assign w_cell_key = r_busy ? r_key : w_key_in;

    // Summary of the flag runs left by the compare.
    assign w_empty   = (r_count == '0);
    assign w_full    = (r_count == CNT_W'(CAPACITY));
    assign w_found   = |(w_le & ~w_lt);
    assign w_pred_ok = w_lt[0];
    assign w_succ_ok = |(w_occ & ~w_le);

    // Decode of the apply cycle.
    always_comb begin
        w_ctl.search = w_accept;
        w_ctl.wr_op  = WR_HOLD;
        w_ctl.sel_op = SEL_NONE;
        n_status     = ST_OK;
        n_hit        = 1'b0;
        n_count      = r_count;
        unique case (r_cmd)
            CMD_INSERT: begin
                if (w_found) begin
                    n_status = ST_NOT_FOUND;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_hit       = 1'b1;
                    w_ctl.wr_op = WR_INSERT;
                    n_count     = r_count + CNT_W'(1);
                end
            end
            CMD_REMOVE, CMD_EXISTS: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else if (w_found) begin
                    n_hit = 1'b1;
                    if (r_cmd == CMD_REMOVE) begin
                        w_ctl.wr_op = WR_RM_LT;
                        n_count     = r_count - CNT_W'(1);
                    end
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            CMD_MIN, CMD_EXTRACT_MIN: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_ctl.sel_op = SEL_MIN;
                    if (r_cmd == CMD_EXTRACT_MIN) begin
                        w_ctl.wr_op = WR_RM_ALL;
                        n_count     = r_count - CNT_W'(1);
                    end
                end
            end
            CMD_MAX, CMD_EXTRACT_MAX: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    // The top key is dropped by shortening the count alone.
                    w_ctl.sel_op = SEL_MAX;
                    if (r_cmd == CMD_EXTRACT_MAX) begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            CMD_PRED, CMD_PRED_REMOVE: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else if (!w_pred_ok) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    w_ctl.sel_op = SEL_PRED;
                    if (r_cmd == CMD_PRED_REMOVE) begin
                        w_ctl.wr_op = WR_RM_PRED;
                        n_count     = r_count - CNT_W'(1);
                    end
                end
            end
            CMD_SUCC, CMD_SUCC_REMOVE: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else if (!w_succ_ok) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    w_ctl.sel_op = SEL_SUCC;
                    if (r_cmd == CMD_SUCC_REMOVE) begin
                        w_ctl.wr_op = WR_RM_LE;
                        n_count     = r_count - CNT_W'(1);
                    end
                end
            end
            CMD_CLEAR: n_count = '0;
            default: ;  // unused command codes leave the set alone
        endcase
        if (!r_busy) begin
            w_ctl.wr_op  = WR_HOLD;
            w_ctl.sel_op = SEL_NONE;
        end
    end

    // The chain of cells.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_WIDTH-1:0] prv_key, nxt_key;
        logic                 prv_lt, prv_le, nxt_lt, nxt_occ;

        if (g == 0) begin : g_first
            assign prv_key = '0;
            assign prv_lt  = 1'b1;
            assign prv_le  = 1'b1;
        end else begin : g_inner_prv
            assign prv_key = w_key[g-1];
            assign prv_lt  = w_lt[g-1];
            assign prv_le  = w_le[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign nxt_key = '0;
            assign nxt_lt  = 1'b0;
            assign nxt_occ = 1'b0;
        end else begin : g_inner_nxt
            assign nxt_key = w_key[g+1];
            assign nxt_lt  = w_lt[g+1];
            assign nxt_occ = w_occ[g+1];
        end

        ose_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .CNT_W     (CNT_W),
            .IDX       (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_key     (w_cell_key),
            .i_count   (r_count),
            .i_prv_key (prv_key),
            .i_prv_lt  (prv_lt),
            .i_prv_le  (prv_le),
            .i_nxt_key (nxt_key),
            .i_nxt_lt  (nxt_lt),
            .i_nxt_occ (nxt_occ),
            .o_key     (w_key[g]),
            .o_lt      (w_lt[g]),
            .o_le      (w_le[g]),
            .o_occ     (w_occ[g]),
            .o_pick    (w_pick[g])
        );
    end

    // At most one cell drives a non-zero key onto the result bus.
    always_comb begin
        w_pick_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_pick_or = w_pick_or | w_pick[i];
        end
    end
    assign w_pick64 = 64'(w_pick_or);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= w_accept;
            if (r_busy) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_command;
            r_key <= w_key_in;
        end
        if (r_busy) begin
            r_status <= n_status;
            r_value  <= w_pick64[31:0];
            r_hit    <= n_hit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_value     = r_value;
    assign o_hit       = r_hit;
    assign o_count     = r_count;

`ifndef SYNTH
    // Sorted distinct keys give a run of less-than flags from cell 0.
    a_lt_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (((w_lt >> 1) & ~w_lt) == '0))
        else $error("less-than flags do not form a run from cell 0");

    // Less-than implies less-or-equal in every cell.
    a_lt_in_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ((w_lt & ~w_le) == '0))
        else $error("less-than flag set without less-or-equal flag");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("key count beyond capacity");

    // A result appears only after an apply cycle.
    a_out_after_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_busy))
        else $error("result word without a preceding apply cycle");

    // The output register is free whenever an apply cycle writes it.
    a_apply_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_out_valid)
        else $error("apply cycle while a result word is still pending");
`endif

endmodule

// ===== tb/sv/tb_ordered_set_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_set_engine: self-checking bench for the ordered set engine
// Request words are driven through the valid/stall handshake while a shadow
// copy of the sorted key set predicts every result word. Results are checked
// field by field, in order, with random idling on both channels, a long
// receiver hold-off and pauses of the sender until the engine has drained.
// ----------------------------------------------------------------------------
module tb_ordered_set_engine;

    import ose_pkg::*;

    localparam int CAPACITY        = 64;
    localparam int KEY_WIDTH       = 32;
    localparam int COUNT_W         = $clog2(CAPACITY + 1);
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_TAIL      = 16;
    localparam int REPORT_LIMIT    = 10;
    localparam int HOLD_OFF_CYCLES = 300;

    // Command codes above clear are not decoded by the engine; it answers
    // them with a neutral result and leaves the set alone.
    localparam t_cmd CMD_SPARE_FIRST = 4'd12;
    localparam t_cmd CMD_SPARE_LAST  = 4'd15;

    typedef enum logic [1:0] {
        STALL_QUIET,
        STALL_SOLID,
        STALL_CHOPPY
    } t_stall_mode;

    // One result word as the engine should deliver it. The command and key
    // of the request ride along so that a mismatch can be traced back.
    typedef struct {
        t_cmd               cmd;
        logic [31:0]        key;
        t_status            status;
        logic [31:0]        value;
        logic               hit;
        logic [COUNT_W-1:0] count;
    } t_set_reply;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    t_cmd               i_command   = CMD_INSERT;
    logic [31:0]        i_key       = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b1;
    t_status            o_status;
    logic [31:0]        o_value;
    logic               o_hit;
    logic [COUNT_W-1:0] o_count;

    // Shadow copy of the set, kept in ascending order, and the result words
    // still owed by the engine, oldest first.
    logic [31:0] held_keys[$];
    t_set_reply  replies_due[$];

    int          failures         = 0;
    int          idle_cycles      = 0;
    bit          sender_idles     = 1'b1;
    int          hold_off_request = 0;
    int          hold_left        = 0;
    int          stall_run        = 0;
    int          stall_pick;
    t_stall_mode stall_mode       = STALL_QUIET;

    ordered_set_engine #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_key       (i_key),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_value     (o_value),
        .o_hit       (o_hit),
        .o_count     (o_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Set behaviour: applies one request to the shadow set and returns the
    // result word that the engine owes for it.
    // ------------------------------------------------------------------------
    function automatic t_set_reply ordered_set_apply(t_cmd cmd, logic [31:0] key);
        t_set_reply reply;
        int         n;
        int         pos;
        int         at;
        reply = '{cmd: cmd, key: key, status: ST_OK, value: '0, hit: 1'b0, count: '0};
        n   = held_keys.size();
        // First position whose key is not below the request key.
        pos = 0;
        while (pos < n && held_keys[pos] < key)
            pos++;
        case (cmd)
            CMD_INSERT: begin
                // A duplicate is reported even when the set is also full.
                if (pos < n && held_keys[pos] == key)
                    reply.status = ST_NOT_FOUND;
                else if (n >= CAPACITY)
                    reply.status = ST_FULL;
                else begin
                    held_keys.insert(pos, key);
                    reply.hit = 1'b1;
                end
            end
            CMD_REMOVE, CMD_EXISTS: begin
                if (n == 0)
                    reply.status = ST_EMPTY;
                else if (pos < n && held_keys[pos] == key) begin
                    reply.hit = 1'b1;
                    if (cmd == CMD_REMOVE)
                        held_keys.delete(pos);
                end else
                    reply.status = ST_NOT_FOUND;
            end
            CMD_MIN, CMD_MAX, CMD_EXTRACT_MIN, CMD_EXTRACT_MAX: begin
                if (n == 0)
                    reply.status = ST_EMPTY;
                else begin
                    at = (cmd == CMD_MIN || cmd == CMD_EXTRACT_MIN) ? 0 : n - 1;
                    reply.value = held_keys[at];
                    if (cmd == CMD_EXTRACT_MIN || cmd == CMD_EXTRACT_MAX)
                        held_keys.delete(at);
                end
            end
            CMD_PRED, CMD_PRED_REMOVE: begin
                if (n == 0)
                    reply.status = ST_EMPTY;
                else if (pos == 0)
                    reply.status = ST_NOT_FOUND;
                else begin
                    reply.value = held_keys[pos - 1];
                    if (cmd == CMD_PRED_REMOVE)
                        held_keys.delete(pos - 1);
                end
            end
            CMD_SUCC, CMD_SUCC_REMOVE: begin
                // The successor lies strictly above the key, so an equal key
                // is stepped over.
                if (pos < n && held_keys[pos] == key)
                    pos++;
                if (n == 0)
                    reply.status = ST_EMPTY;
                else if (pos >= n)
                    reply.status = ST_NOT_FOUND;
                else begin
                    reply.value = held_keys[pos];
                    if (cmd == CMD_SUCC_REMOVE)
                        held_keys.delete(pos);
                end
            end
            CMD_CLEAR: begin
                held_keys.delete();
            end
            default: begin
            end
        endcase
        reply.count = COUNT_W'(held_keys.size());
        return reply;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    // Idle cycles before a request word: mostly none or a few, now and then
    // a long gap.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!sender_idles || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Keys lean towards held keys and their neighbours, so that duplicates,
    // hits and exact matches in the searches come up often.
    function automatic logic [31:0] pick_key();
        int          r;
        logic [31:0] base;
        r = $urandom_range(0, 99);
        if (r < 40 && held_keys.size() != 0) begin
            base = held_keys[$urandom_range(0, held_keys.size() - 1)];
            case ($urandom_range(0, 3))
                0:       return base - 32'd1;
                1:       return base + 32'd1;
                default: return base;
            endcase
        end
        if (r < 60)
            return 32'($urandom_range(0, 200));
        if (r < 70)
            return 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
        if (r < 80) begin
            case ($urandom_range(0, 5))
                0:       return 32'h0000_0000;
                1:       return 32'h0000_0001;
                2:       return 32'h7FFF_FFFF;
                3:       return 32'h8000_0000;
                4:       return 32'hFFFF_FFFE;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    // Inserts take the given share in thousandths; clear and the undecoded
    // codes are rare so that the set can grow to its capacity.
    function automatic t_cmd pick_command(int insert_permille);
        int r;
        r = $urandom_range(0, 999);
        if (r < insert_permille)
            return CMD_INSERT;
        if (r >= 996)
            return CMD_CLEAR;
        if (r >= 986)
            return t_cmd'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        return t_cmd'($urandom_range(CMD_REMOVE, CMD_SUCC_REMOVE));
    endfunction

    // Offers one request word and returns at the edge that accepts it. Valid
    // is only lowered when a gap follows, so back-to-back words keep it high.
    task automatic send_word(input t_cmd cmd, input logic [31:0] key);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_key      <= key;
        do @(posedge i_clk); while (o_in_stall);
        replies_due.push_back(ordered_set_apply(cmd, key));
    endtask

    // The sender stops until every outstanding result word has come back.
    task automatic drain_replies();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (replies_due.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------
    // Every command, several of them on the empty set, the extreme keys, duplicates, absent
    // keys, searches with no answer and the undecoded command codes.
    task automatic test_directed_set_basics();
        send_word(CMD_REMOVE,      32'h0000_0000);
        send_word(CMD_EXISTS,      32'hFFFF_FFFF);
        send_word(CMD_MIN,         32'h0000_0000);
        send_word(CMD_EXTRACT_MAX, 32'h0000_0000);
        send_word(CMD_PRED_REMOVE, 32'hFFFF_FFFF);
        send_word(CMD_SUCC,        32'h0000_0000);
        send_word(CMD_INSERT,      32'h0000_0000);
        send_word(CMD_INSERT,      32'hFFFF_FFFF);
        send_word(CMD_INSERT,      32'h0000_0000);
        send_word(CMD_INSERT,      32'h8000_0000);
        send_word(CMD_EXISTS,      32'h8000_0000);
        send_word(CMD_EXISTS,      32'h0000_0005);
        send_word(CMD_REMOVE,      32'h0000_0005);
        send_word(CMD_PRED,        32'h0000_0000);
        send_word(CMD_SUCC,        32'hFFFF_FFFF);
        send_word(CMD_SUCC,        32'h0000_0000);
        send_word(CMD_PRED,        32'hFFFF_FFFF);
        send_word(CMD_MAX,         32'h0000_0000);
        send_word(CMD_SPARE_FIRST, 32'hFFFF_FFFF);
        send_word(CMD_SPARE_LAST,  32'h0000_0000);
        send_word(CMD_PRED_REMOVE, 32'h8000_0001);
        send_word(CMD_SUCC_REMOVE, 32'h0000_0001);
        send_word(CMD_EXTRACT_MIN, 32'hFFFF_FFFF);
        send_word(CMD_INSERT,      32'h1234_5678);
        send_word(CMD_CLEAR,       32'hFFFF_FFFF);
    endtask

    // Fills the set to capacity, checks that a duplicate is still reported
    // as such on a full set, then works close to the limit for a while.
    task automatic test_capacity_limit();
        send_word(CMD_CLEAR, $urandom);
        while (held_keys.size() < CAPACITY)
            send_word(CMD_INSERT, $urandom);
        send_word(CMD_INSERT, held_keys[$urandom_range(0, CAPACITY - 1)]);
        send_word(CMD_INSERT, $urandom);
        send_word(CMD_INSERT, 32'h0000_0000);
        send_word(CMD_EXTRACT_MAX, 32'h0000_0000);
        send_word(CMD_INSERT, 32'hFFFF_FFFF);
        send_word(CMD_INSERT, 32'hFFFF_FFFE);
        test_random_traffic(40, 850);
        send_word(CMD_CLEAR, 32'h0000_0000);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering, so the engine fills and stalls its request channel. The
    // sender pauses for a full drain before and after.
    task automatic test_backpressure();
        drain_replies();
        sender_idles     = 1'b0;
        hold_off_request = HOLD_OFF_CYCLES;
        repeat (16) send_word(pick_command(500), pick_key());
        drain_replies();
        sender_idles     = 1'b1;
    endtask

    task automatic test_random_traffic(input int words, input int insert_permille);
        repeat (words) send_word(pick_command(insert_permille), pick_key());
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall pattern with quiet stretches, solid stalls
    // and choppy ones, plus the long hold-off that a test may ask for.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_off_request != 0) begin
            hold_left        = hold_off_request;
            hold_off_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (stall_run == 0) begin
                stall_pick = $urandom_range(0, 99);
                if (stall_pick < 20) begin
                    stall_mode = STALL_QUIET;
                    stall_run  = $urandom_range(20, 80);
                end else if (stall_pick < 28) begin
                    stall_mode = STALL_SOLID;
                    stall_run  = $urandom_range(8, 40);
                end else begin
                    stall_mode = STALL_CHOPPY;
                    stall_run  = $urandom_range(4, 16);
                end
            end
            stall_run--;
            case (stall_mode)
                STALL_QUIET: i_out_stall <= 1'b0;
                STALL_SOLID: i_out_stall <= 1'b1;
                default:     i_out_stall <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    // Every accepted result word is matched against the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (replies_due.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("%0t: result word with none outstanding: status %0d value %h",
                             $realtime, o_status, o_value);
            end else if (o_status !== replies_due[0].status
                         || o_value !== replies_due[0].value
                         || o_hit   !== replies_due[0].hit
                         || o_count !== replies_due[0].count) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("%0t: command %0d key %h: expected status %0d value %h hit %0d count %0d,",
                             $realtime, replies_due[0].cmd, replies_due[0].key,
                             replies_due[0].status, replies_due[0].value,
                             replies_due[0].hit, replies_due[0].count,
                             " got status %0d value %h hit %0d count %0d",
                             o_status, o_value, o_hit, o_count);
                void'(replies_due.pop_front());
            end else
                void'(replies_due.pop_front());
        end
    end

    // Watchdog: ends the run when neither channel moves a word for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_set_basics();
        test_capacity_limit();
        test_backpressure();
        test_random_traffic(400, 700);
        // A stretch in which the sender never idles.
        sender_idles = 1'b0;
        test_random_traffic(300, 550);
        sender_idles = 1'b1;
        test_random_traffic(300, 200);
        test_backpressure();
        test_random_traffic(700, 450);

        drain_replies();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (failures == 0 && replies_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ose_pkg.sv
hdl/ose_cell.sv
hdl/ordered_set_engine.sv
tb/sv/tb_ordered_set_engine.sv
